// ===== design/assert_macros.svh =====
// Assertion macros shared by the tokenizer RTL.
// Included by the modules that check their own logic; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Overlapping implication: cons holds in the same cycle as ante.
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication: cons holds in the cycle after ante.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== design/wta_pkg.sv =====
// Package for the word tokenizer: widths, codes, state and result types,
// and the per-byte word classification function. No dependencies.
`default_nettype none

package wta_pkg;

   localparam int MAX_WORD_DEF = 64;
   localparam int CNT_W        = 7;
   localparam int WNUM_W       = 16;
   localparam int MAX_RES      = 3;

   localparam logic [7:0] APOS      = 8'h27;
   localparam logic       KIND_CHAR = 1'b0;
   localparam logic       KIND_END  = 1'b1;

   // Tokenizer state carried from one byte to the next
   typedef struct packed {
      logic              in_word;
      logic              quote_seen;
      logic              quote_pending;
      logic [CNT_W-1:0]  char_count;
      logic [WNUM_W-1:0] word_counter;
      logic              overflowed;
      logic              at_line_start;
      logic [7:0]        held_byte;
      logic              held_valid;
   } tok_state_type;

   localparam tok_state_type ST_RESET = '{
      in_word:       1'b0,
      quote_seen:    1'b0,
      quote_pending: 1'b0,
      char_count:    '0,
      word_counter:  '0,
      overflowed:    1'b0,
      at_line_start: 1'b1,
      held_byte:     8'h00,
      held_valid:    1'b0
   };

   // One result transaction, less the word number and last flag
   typedef struct packed {
      logic       kind;
      logic [7:0] ch;
      logic       trunc;
   } res_type;

   // Outcome of classifying one byte: new state and up to two results
   typedef struct packed {
      tok_state_type st;
      logic [1:0]    n;
      res_type [1:0] r;
   } take_type;

   function automatic take_type take_byte(tok_state_type s, logic [7:0] b,
                                          logic [CNT_W-1:0] lim);
      take_type   o;
      logic [7:0] low;
      logic       letter;
      logic [1:0] n;
      o      = '0;
      o.st   = s;
      n      = 2'd0;
      low    = b | 8'h20;
      letter = !b[7] && (low >= 8'h61) && (low <= 8'h7a);
      if (!s.in_word) begin
         // first letter opens a word; the limit is at least one
         if (letter) begin
            o.st.in_word       = 1'b1;
            o.st.quote_seen    = 1'b0;
            o.st.quote_pending = 1'b0;
            o.st.overflowed    = 1'b0;
            o.st.char_count    = CNT_W'(1);
            o.r[0]             = '{kind: KIND_CHAR, ch: low, trunc: 1'b0};
            n                  = 2'd1;
         end
      end else if (letter) begin
         // a held apostrophe is released ahead of the letter
         if (s.quote_pending) begin
            o.st.quote_pending = 1'b0;
            if (o.st.char_count < lim) begin
               o.r[0]          = '{kind: KIND_CHAR, ch: APOS, trunc: 1'b0};
               o.st.char_count = o.st.char_count + CNT_W'(1);
               n               = 2'd1;
            end else begin
               o.st.overflowed = 1'b1;
            end
         end
         if (o.st.char_count < lim) begin
            o.r[n[0]]       = '{kind: KIND_CHAR, ch: low, trunc: 1'b0};
            o.st.char_count = o.st.char_count + CNT_W'(1);
            n               = n + 2'd1;
         end else begin
            o.st.overflowed = 1'b1;
         end
      end else if ((b == APOS) && !s.quote_seen) begin
         o.st.quote_seen    = 1'b1;
         o.st.quote_pending = 1'b1;
      end else begin
         // any other byte closes the word
         o.r[0]             = '{kind: KIND_END, ch: 8'h00, trunc: s.overflowed};
         o.st.in_word       = 1'b0;
         o.st.quote_seen    = 1'b0;
         o.st.quote_pending = 1'b0;
         o.st.char_count    = '0;
         o.st.overflowed    = 1'b0;
         if (s.word_counter != '1) begin
            o.st.word_counter = s.word_counter + WNUM_W'(1);
         end
         n = 2'd1;
      end
      o.n = n;
      return o;
   endfunction

endpackage

`default_nettype wire

// ===== design/wta_step.sv =====
// Next-state and result logic for one input byte of the tokenizer.
// Depends on wta_pkg (state/result types and take_byte).
`default_nettype none

module wta_step #(
   parameter int MAX_WORD = wta_pkg::MAX_WORD_DEF
) (
   input  wta_pkg::tok_state_type st,
   input  logic [7:0]             in_byte,
   input  logic                   line_end,
   output wta_pkg::tok_state_type nst,
   output wta_pkg::res_type       res [wta_pkg::MAX_RES],
   output logic [1:0]             n
);
   import wta_pkg::*;

   localparam logic [CNT_W-1:0] LIM = CNT_W'(MAX_WORD - 1);

   take_type      t_held;
   take_type      t_byte;
   tok_state_type s_mid;

   // held first byte runs ahead of the current byte
   always_comb begin
      t_held = take_byte(st, st.held_byte, LIM);
      s_mid  = st.held_valid ? t_held.st : st;
      s_mid.held_valid = 1'b0;
      t_byte = take_byte(s_mid, in_byte, LIM);
   end

   // gather results in order, then apply end of line
   always_comb begin
      nst = st;
      n   = 2'd0;
      for (int i = 0; i < MAX_RES; i++) begin
         res[i] = '0;
      end
      if (st.at_line_start) begin
         nst.at_line_start = 1'b0;
         nst.held_byte     = in_byte;
         nst.held_valid    = 1'b1;
      end else begin
         nst = t_byte.st;
         if (st.held_valid && (t_held.n != 2'd0)) begin
            res[0] = t_held.r[0];
            n      = 2'd1;
         end
         for (int i = 0; i < 2; i++) begin
            if (2'(i) < t_byte.n) begin
               res[n] = t_byte.r[i];
               n      = n + 2'd1;
            end
         end
      end
      if (line_end) begin
         if (nst.in_word) begin
            res[n] = '{kind: KIND_END, ch: 8'h00, trunc: nst.overflowed};
            n      = n + 2'd1;
         end
         nst.in_word       = 1'b0;
         nst.quote_seen    = 1'b0;
         nst.quote_pending = 1'b0;
         nst.char_count    = '0;
         nst.overflowed    = 1'b0;
         nst.word_counter  = '0;
         nst.at_line_start = 1'b1;
         nst.held_byte     = 8'h00;
         nst.held_valid    = 1'b0;
      end
   end

endmodule

`default_nettype wire

// ===== design/word_tokenizer_with_apostrophe.sv =====
// Word tokenizer with apostrophe, top level: state registers and the result
// queue. Depends on wta_pkg, wta_step and assert_macros.svh.
//
// Bytes of a line enter one per cycle on req_ unless the result queue stalls them;
// words leave as lower-cased character transactions and an end-of-word transaction
// on rsp_, each tagged with the word's index in the line. The first byte of a line
// is held and worked together with the second, so a one-byte line yields nothing.
// A byte is classified in the cycle it is accepted and its results (zero to three)
// land in a three-entry result queue; after a byte that yields no result the next
// byte may be taken in the following cycle, otherwise the next byte is taken in the
// cycle its last result is taken. Words longer than MAX_WORD-1 characters are cut
// and flagged on the end transaction.
`default_nettype none
`include "assert_macros.svh"

module word_tokenizer_with_apostrophe #(
   parameter int MAX_WORD = wta_pkg::MAX_WORD_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [7:0]                 req_in_byte,
   input  logic                       req_line_end,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic                       rsp_kind,
   output logic [7:0]                 rsp_out_char,
   output logic [wta_pkg::WNUM_W-1:0] rsp_word_number,
   output logic                       rsp_truncated,
   output logic                       rsp_last_of_run
);
   import wta_pkg::*;

   tok_state_type     st_ff, st_in, step_st;
   res_type           res_ff [MAX_RES];
   res_type           res_in [MAX_RES];
   res_type           step_res [MAX_RES];
   logic [1:0]        step_n;
   logic [1:0]        cnt_ff, cnt_in;
   logic [WNUM_W-1:0] wnum_ff, wnum_in;
   logic              accept, pop;

   wta_step #(.MAX_WORD(MAX_WORD)) u_step (
      .st       (st_ff),
      .in_byte  (req_in_byte),
      .line_end (req_line_end),
      .nst      (step_st),
      .res      (step_res),
      .n        (step_n)
   );

   // handshake: take a byte once the queue drains this cycle
   assign pop       = rsp_valid && rsp_ready;
   assign req_ready = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_ready);
   assign accept    = req_valid && req_ready;

   // queue load on accept, shift on pop
   always_comb begin
      st_in   = accept ? step_st : st_ff;
      res_in  = res_ff;
      cnt_in  = cnt_ff;
      wnum_in = wnum_ff;
      if (accept) begin
         res_in  = step_res;
         cnt_in  = step_n;
         wnum_in = st_ff.word_counter;
      end else if (pop) begin
         res_in[0] = res_ff[1];
         res_in[1] = res_ff[2];
         cnt_in    = cnt_ff - 2'd1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_RESET;
         cnt_ff <= 2'd0;
      end else begin
         st_ff  <= st_in;
         cnt_ff <= cnt_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      res_ff  <= res_in;
      wnum_ff <= wnum_in;
   end

   // output transaction is the queue head
   assign rsp_valid       = (cnt_ff != 2'd0);
   assign rsp_kind        = res_ff[0].kind;
   assign rsp_out_char    = res_ff[0].ch;
   assign rsp_truncated   = res_ff[0].trunc;
   assign rsp_word_number = wnum_ff;
   assign rsp_last_of_run = (cnt_ff == 2'd1);

   // checks
   `ASSERT_SAME(a_accept_drained, clock, reset, accept, cnt_ff <= 2'd1, "byte taken over full queue")
   `ASSERT_SAME(a_end_no_char, clock, reset, rsp_valid && (rsp_kind == KIND_END), rsp_out_char == 8'h00, "end marker carries a character")
   `ASSERT_SAME(a_trunc_on_end, clock, reset, rsp_valid && rsp_truncated, rsp_kind == KIND_END, "truncation on a character")
   `ASSERT_NEXT(a_line_restart, clock, reset, accept && req_line_end, st_ff.at_line_start && (st_ff.word_counter == '0) && !st_ff.in_word, "line end did not restart")
   `ASSERT_ALWAYS(a_count_limit, clock, reset, st_ff.char_count <= CNT_W'(MAX_WORD - 1), "word length past limit")

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for word_tokenizer_with_apostrophe. Directed lines, random text and
// long-word lines go in; every transaction out is checked by a bench model.
// Depends on wta_pkg and the tokenizer RTL.
module testbench;
   import wta_pkg::*;

   localparam int WORD_LIMIT = MAX_WORD_DEF;
   localparam int N_RANDOM   = 72;

   // one input byte with its pacing
   typedef struct {
      logic [7:0] b;
      logic       le;
      int         gap;
      bit         drain;
      bit         rush;
   } byte_item_type;

   // one output token
   typedef struct packed {
      logic              kind;
      logic [7:0]        ch;
      logic [WNUM_W-1:0] wnum;
      logic              trunc;
      logic              last;
   } token_type;

   // lexer state kept by the bench
   typedef struct {
      bit              in_word;
      bit              quote_seen;
      bit              quote_pending;
      bit [CNT_W-1:0]  n_chars;
      bit [WNUM_W-1:0] word_idx;
      bit              dropped;
      bit              line_start;
      bit [7:0]        first_byte;
      bit              first_held;
   } lexer_type;

   logic              clock           = 1'b0;
   logic              reset           = 1'b1;
   logic              req_valid       = 1'b0;
   logic              req_ready;
   logic [7:0]        req_in_byte     = 8'h00;
   logic              req_line_end    = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready       = 1'b0;
   logic              rsp_kind;
   logic [7:0]        rsp_out_char;
   logic [WNUM_W-1:0] rsp_word_number;
   logic              rsp_truncated;
   logic              rsp_last_of_run;
   logic              rush_q          = 1'b0;

   byte_item_type feed_q[$];
   logic [7:0]    line_buf[$];
   token_type     want_tokens[$];
   token_type     got_tokens[$];
   lexer_type     lx;

   byte_item_type cur;
   bit         offering   = 1'b0;
   bit         gap_armed  = 1'b0;
   int         gap_left   = 0;
   bit         drain_next = 1'b0;
   bit         rush_on    = 1'b0;
   int         gap_mode   = 1;
   int         n_fed      = 0;
   int         n_results  = 0;
   int         rx_mode    = 1;
   int         stall_left = 0;
   int         n_errors   = 0;

   word_tokenizer_with_apostrophe u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .req_line_end    (req_line_end),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_out_char    (rsp_out_char),
      .rsp_word_number (rsp_word_number),
      .rsp_truncated   (rsp_truncated),
      .rsp_last_of_run (rsp_last_of_run)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------- tokenizer model ----------------

   function automatic bit is_letter(logic [7:0] b);
      logic [7:0] low;
      low = b | 8'h20;
      return !b[7] && (low >= 8'h61) && (low <= 8'h7a);
   endfunction

   function automatic void note_token(logic k, logic [7:0] c, logic t);
      want_tokens.push_back('{kind: k, ch: c, wnum: lx.word_idx, trunc: t, last: 1'b0});
   endfunction

   function automatic void clear_word();
      lx.in_word       = 1'b0;
      lx.quote_seen    = 1'b0;
      lx.quote_pending = 1'b0;
      lx.n_chars       = '0;
      lx.dropped       = 1'b0;
   endfunction

   // characters past the length limit are dropped and flagged
   function automatic void store_char(logic [7:0] c);
      if (lx.n_chars < CNT_W'(WORD_LIMIT - 1)) begin
         note_token(KIND_CHAR, c, 1'b0);
         lx.n_chars = lx.n_chars + 1'b1;
      end else begin
         lx.dropped = 1'b1;
      end
   endfunction

   function automatic void close_word();
      note_token(KIND_END, 8'h00, lx.dropped);
      clear_word();
      if (lx.word_idx != '1) lx.word_idx = lx.word_idx + 1'b1;
   endfunction

   function automatic void lex_byte(logic [7:0] b);
      if (!lx.in_word) begin
         if (is_letter(b)) begin
            clear_word();
            lx.in_word = 1'b1;
            store_char(b | 8'h20);
         end
      end else if (is_letter(b)) begin
         // a held apostrophe goes out only once a letter follows
         if (lx.quote_pending) begin
            lx.quote_pending = 1'b0;
            store_char(APOS);
         end
         store_char(b | 8'h20);
      end else if (b == APOS && !lx.quote_seen) begin
         lx.quote_seen    = 1'b1;
         lx.quote_pending = 1'b1;
      end else begin
         close_word();
      end
   endfunction

   // expected tokens of one accepted byte
   function automatic void tokenize(logic [7:0] b, logic le);
      int n_prior;
      n_prior = want_tokens.size();
      if (lx.line_start) begin
         // first byte of a line waits for the second
         lx.line_start = 1'b0;
         lx.first_byte = b;
         lx.first_held = 1'b1;
      end else begin
         if (lx.first_held) begin
            lx.first_held = 1'b0;
            lex_byte(lx.first_byte);
         end
         lex_byte(b);
      end
      if (le) begin
         if (lx.in_word) close_word();
         clear_word();
         lx.word_idx   = '0;
         lx.line_start = 1'b1;
         lx.first_byte = 8'h00;
         lx.first_held = 1'b0;
      end
      if (want_tokens.size() > n_prior) want_tokens[want_tokens.size() - 1].last = 1'b1;
   endfunction

   function automatic void flag_error(string what, token_type want, token_type got);
      n_errors++;
      if (n_errors <= 10)
         $display("%0t %s: expected kind=%0d char=%h word=%0d trunc=%0d last=%0d",
                  $realtime, what, want.kind, want.ch, want.wnum, want.trunc, want.last,
                  " / got kind=%0d char=%h word=%0d trunc=%0d last=%0d",
                  got.kind, got.ch, got.wnum, got.trunc, got.last);
   endfunction

   // ---------------- stimulus building ----------------

   function automatic void put_text(string s);
      for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
   endfunction

   // moves the line buffer into the feed queue, line end on its last byte
   function automatic void flush_line();
      byte_item_type it;
      for (int i = 0; i < line_buf.size(); i++) begin
         it.b     = line_buf[i];
         it.le    = (i == line_buf.size() - 1);
         it.drain = drain_next;
         it.rush  = rush_on;
         it.gap   = (rush_on || gap_mode == 0) ? 0 : $urandom_range(0, 6);
         drain_next = 1'b0;
         feed_q.push_back(it);
         n_fed++;
      end
      line_buf.delete();
   endfunction

   function automatic logic [7:0] rand_letter();
      logic [7:0] c;
      c = 8'h61 + 8'($urandom_range(0, 25));
      if ($urandom_range(0, 1) == 1) c = c ^ 8'h20;
      return c;
   endfunction

   function automatic logic [7:0] rand_delim();
      logic [7:0] c;
      if ($urandom_range(0, 2) == 0) return 8'h20;
      do c = 8'($urandom); while (is_letter(c) || c == APOS);
      return c;
   endfunction

   function automatic void add_long(int n, string tail);
      repeat (n) line_buf.push_back(rand_letter());
      put_text(tail);
      flush_line();
   endfunction

   // mostly well-formed lines of words; some raw noise lines
   function automatic void add_random_line();
      int n_words;
      int len;
      int apos_at;
      gap_mode = $urandom_range(0, 3);
      if ($urandom_range(0, 4) == 0) begin
         len = $urandom_range(1, 10);
         repeat (len) line_buf.push_back(8'($urandom));
      end else begin
         n_words = $urandom_range(0, 5);
         repeat ($urandom_range(0, 2)) line_buf.push_back(rand_delim());
         for (int w = 0; w < n_words; w++) begin
            len     = ($urandom_range(0, 15) == 0) ? $urandom_range(58, 70)
                                                   : $urandom_range(1, 8);
            apos_at = $urandom_range(0, 2 * len + 2);
            for (int i = 0; i < len; i++) begin
               if (i == apos_at && i > 0) begin
                  line_buf.push_back(APOS);
                  if ($urandom_range(0, 5) == 0) line_buf.push_back(APOS);
               end
               line_buf.push_back(rand_letter());
            end
            if (apos_at == len) line_buf.push_back(APOS);
            if (w < n_words - 1 || $urandom_range(0, 1) == 1)
               repeat ($urandom_range(1, 2)) line_buf.push_back(rand_delim());
         end
         if (line_buf.size() == 0) line_buf.push_back(rand_letter());
      end
      flush_line();
   endfunction

   // ---------------- driver ----------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid    <= 1'b0;
         req_in_byte  <= 8'h00;
         req_line_end <= 1'b0;
         rush_q       <= 1'b0;
         offering     = 1'b0;
         gap_armed    = 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            tokenize(cur.b, cur.le);
            offering = 1'b0;
         end
         // a drain item waits until every pending result is back
         if (!offering && feed_q.size() > 0 &&
             !(feed_q[0].drain && (want_tokens.size() > 0 || got_tokens.size() > 0))) begin
            if (!gap_armed) begin
               gap_left  = feed_q[0].gap;
               gap_armed = 1'b1;
            end
            if (gap_left > 0) begin
               gap_left--;
            end else begin
               cur          = feed_q.pop_front();
               gap_armed    = 1'b0;
               offering     = 1'b1;
               req_in_byte  <= cur.b;
               req_line_end <= cur.le;
               rush_q       <= cur.rush;
            end
         end
         req_valid <= offering;
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got_tokens.push_back('{kind: rsp_kind, ch: rsp_out_char, wnum: rsp_word_number,
                                   trunc: rsp_truncated, last: rsp_last_of_run});
            n_results++;
            if (n_results % 40 == 0) rx_mode = $urandom_range(0, 2);
            // one long hold so the result queue fills and input stalls
            if (n_results == 100)
               stall_left = 200;
            else if (rush_q || rx_mode == 0)
               stall_left = 0;
            else
               stall_left = $urandom_range(0, 6);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // compare away from the rising edge, after the model has run
   always @(negedge clock) begin : check_tokens
      token_type got;
      token_type want;
      while (got_tokens.size() > 0) begin
         got = got_tokens.pop_front();
         if (want_tokens.size() == 0) begin
            flag_error("unexpected result", 'x, got);
         end else begin
            want = want_tokens.pop_front();
            if (got !== want) flag_error("mismatch", want, got);
         end
      end
   end

   // ---------------- sequence ----------------
   initial begin
      int start_n;
      lx            = '{default: 0};
      lx.line_start = 1'b1;

      // one-byte line, then a two-byte line
      put_text("A");
      flush_line();
      put_text("Hi");
      flush_line();
      // zero and high bytes, letter-range neighbors, second and trailing apostrophes
      put_text("Z");
      line_buf.push_back(8'h00);
      put_text("z's'q");
      line_buf.push_back(8'hC1);
      line_buf.push_back(8'hFF);
      put_text("@[`{ab' yZ'");
      flush_line();

      drain_next = 1'b1;
      start_n    = n_fed;
      while (n_fed - start_n < N_RANDOM) add_random_line();

      // word length limit, with an apostrophe right at the edge
      drain_next = 1'b1;
      gap_mode   = 2;
      add_long(WORD_LIMIT - 1, "'x.");
      add_long(WORD_LIMIT - 2, "'x ");
      add_long(WORD_LIMIT - 2, "' ");
      add_long(WORD_LIMIT, "");

      // a short line sent with no gaps on either side
      drain_next = 1'b1;
      rush_on    = 1'b1;
      put_text("ok, go");
      flush_line();
      rush_on = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (feed_q.size() > 0 || req_valid) @(posedge clock);
      while (want_tokens.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (want_tokens.size() > 0) begin
         $display("%0d expected results never arrived", want_tokens.size());
         n_errors += want_tokens.size();
      end
      if (n_errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #(30_000_000);
      $display("Regression FAIL");
      $finish;
   end

endmodule
